FILE: hw/rtl/nalsplit_pkg.sv
// Shared types, widths and helpers for the Annex B NAL unit splitter.
// No dependencies; compiled before the interfaces and the top level.

package nalsplit_pkg;

	// Payload length counter width and its saturation value
	localparam int LENGTH_BITS = 20;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	// Fixed field widths of the stream channels
	localparam int BYTE_W = 8;
	localparam int TYPE_W = 5;
	localparam int PLEN_W = 20;

	// Window and result queue sizing
	localparam int WIN_DEPTH  = 4;
	localparam int MAX_EMIT   = 5;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	// NAL header fields
	localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1f;
	localparam logic [TYPE_W-1:0] NAL_TYPE_IDR  = 5'd5;

	// Start code bytes
	localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

	typedef logic [BYTE_W-1:0] byte_t;

	// One output transaction
	typedef struct packed {
		byte_t               out_byte;
		logic                first_of_nal;
		logic                last_of_nal;
		logic [TYPE_W-1:0]   nal_type;
		logic                key_frame;
		logic [PLEN_W-1:0]   payload_length;
	} nal_res_t;

	// Saturating add of a small increment to the length counter
	function automatic logic [LENGTH_BITS-1:0] len_sat_add(
		input logic [LENGTH_BITS-1:0] base,
		input logic [2:0]             inc
	);
		logic [LENGTH_BITS:0] sum;
		sum = {1'b0, base} + (LENGTH_BITS+1)'(inc);
		if (sum > {1'b0, LEN_MAX}) begin
			return LEN_MAX;
		end
		return sum[LENGTH_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/nalsplit_in_if.sv
// Byte stream channel into the NAL splitter: valid/ready plus payload.
// Depends on nalsplit_pkg for field widths.

interface nalsplit_in_if;
	logic                          valid;
	logic                          ready;
	logic [nalsplit_pkg::BYTE_W-1:0] data_byte;
	logic                          buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

FILE: hw/rtl/nalsplit_out_if.sv
// NAL payload channel out of the NAL splitter: valid/ready plus payload.
// Depends on nalsplit_pkg for field widths.

interface nalsplit_out_if;
	logic                            valid;
	logic                            ready;
	logic [nalsplit_pkg::BYTE_W-1:0] out_byte;
	logic                            first_of_nal;
	logic                            last_of_nal;
	logic [nalsplit_pkg::TYPE_W-1:0] nal_type;
	logic                            key_frame;
	logic [nalsplit_pkg::PLEN_W-1:0] payload_length;

	modport source (
		output valid, output out_byte, output first_of_nal, output last_of_nal,
		output nal_type, output key_frame, output payload_length, input ready
	);
	modport sink (
		input valid, input out_byte, input first_of_nal, input last_of_nal,
		input nal_type, input key_frame, input payload_length, output ready
	);
endinterface

FILE: hw/rtl/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter.
// Depends on nalsplit_pkg, nalsplit_in_if and nalsplit_out_if.
//
// The splitter takes one stream byte per cycle while its result queue has room
// and hands out NAL payload bytes with the 00 00 00 01 start codes stripped. A
// byte is processed in the cycle it is accepted: a four-byte hold window and a
// single compare decide what leaves, and the results go into an 8-entry result
// queue that feeds the output port. In steady flow each byte yields at most one
// result, so one byte is taken every cycle while the output keeps draining. The
// final byte of a buffer flushes the window and yields up to five results at
// once; these drain one per cycle while the output is ready, and the input is
// held off while the queue holds more than three results.

module annexb_nal_unit_splitter (
	input  logic                   clk,
	input  logic                   arst_n,
	nalsplit_in_if.sink            byte_stream,
	nalsplit_out_if.source         nal_stream
);

	// Parser state
	nalsplit_pkg::byte_t                  win_q [nalsplit_pkg::WIN_DEPTH];
	logic [2:0]                           cnt_q;
	logic                                 inside_q;
	logic                                 first_q;
	logic [nalsplit_pkg::TYPE_W-1:0]      type_q;
	logic [nalsplit_pkg::LENGTH_BITS-1:0] bc_q;

	nalsplit_pkg::byte_t                  win_n [nalsplit_pkg::WIN_DEPTH];
	logic [2:0]                           cnt_n;
	logic                                 inside_n;
	logic                                 first_n;
	logic [nalsplit_pkg::TYPE_W-1:0]      type_n;
	logic [nalsplit_pkg::LENGTH_BITS-1:0] bc_n;

	// Step results
	nalsplit_pkg::byte_t                  q_byte [nalsplit_pkg::MAX_EMIT];
	nalsplit_pkg::nal_res_t               res [nalsplit_pkg::MAX_EMIT];
	logic [2:0]                           n_emit;
	logic                                 has_last;
	logic [2:0]                           last_idx;
	logic [nalsplit_pkg::LENGTH_BITS-1:0] last_len;
	logic [nalsplit_pkg::LENGTH_BITS-1:0] one_len;
	logic [nalsplit_pkg::LENGTH_BITS-1:0] end_len;
	logic [nalsplit_pkg::TYPE_W-1:0]      hdr_type;
	logic                                 sc_inside;
	logic                                 sc_search;
	nalsplit_pkg::byte_t                  b;
	logic                                 b_end;

	// Result queue
	nalsplit_pkg::nal_res_t               queue_q [nalsplit_pkg::QUEUE_DEPTH];
	logic [nalsplit_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [nalsplit_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [nalsplit_pkg::QCNT_W-1:0]      qcnt_q;
	logic                                 push;
	logic                                 pop;
	logic [nalsplit_pkg::QCNT_W-1:0]      push_cnt;

	assign b     = byte_stream.data_byte;
	assign b_end = byte_stream.buffer_end;

	// Handshakes: room for a full flush before taking a byte
	assign byte_stream.ready = qcnt_q <= nalsplit_pkg::QCNT_W'(nalsplit_pkg::QUEUE_DEPTH
		- nalsplit_pkg::MAX_EMIT);
	assign push     = byte_stream.valid && byte_stream.ready;
	assign nal_stream.valid = qcnt_q != '0;
	assign pop      = nal_stream.valid && nal_stream.ready;
	assign push_cnt = push ? nalsplit_pkg::QCNT_W'(n_emit) : '0;

	// Held bytes followed by the incoming one
	always_comb begin
		for (int k = 0; k < nalsplit_pkg::MAX_EMIT; k++) begin
			q_byte[k] = (3'(k) < cnt_q) ? win_q[k[1:0]] : b;
		end
	end

	// Start code detection, lengths and header type
	assign sc_inside = (cnt_q == 3'd4)
		? (win_q[1] == nalsplit_pkg::SC_ZERO && win_q[2] == nalsplit_pkg::SC_ZERO &&
		   win_q[3] == nalsplit_pkg::SC_ZERO && b == nalsplit_pkg::SC_ONE)
		: (cnt_q == 3'd3 && win_q[0] == nalsplit_pkg::SC_ZERO &&
		   win_q[1] == nalsplit_pkg::SC_ZERO && win_q[2] == nalsplit_pkg::SC_ZERO &&
		   b == nalsplit_pkg::SC_ONE);
	assign sc_search = (cnt_q >= 3'd3) && win_q[1] == nalsplit_pkg::SC_ZERO &&
		win_q[2] == nalsplit_pkg::SC_ZERO && win_q[3] == nalsplit_pkg::SC_ZERO &&
		b == nalsplit_pkg::SC_ONE;
	assign one_len  = nalsplit_pkg::len_sat_add(bc_q, 3'd1);
	assign end_len  = nalsplit_pkg::len_sat_add(bc_q, cnt_q + 3'd1);
	assign hdr_type = first_q ? 5'(q_byte[0] & nalsplit_pkg::NAL_TYPE_MASK) : type_q;

	// Next state and emission count
	always_comb begin
		win_n    = win_q;
		cnt_n    = cnt_q;
		inside_n = inside_q;
		first_n  = first_q;
		bc_n     = bc_q;
		n_emit   = 3'd0;
		has_last = 1'b0;
		last_idx = 3'd0;
		last_len = '0;
		if (!inside_q) begin
			// searching: slide the window
			win_n[0] = win_q[1];
			win_n[1] = win_q[2];
			win_n[2] = win_q[3];
			win_n[3] = b;
			cnt_n    = (cnt_q == 3'd4) ? 3'd4 : cnt_q + 3'd1;
			if (b_end) begin
				cnt_n   = 3'd0;
				first_n = 1'b0;
				bc_n    = '0;
			end else if (sc_search) begin
				cnt_n    = 3'd0;
				inside_n = 1'b1;
				first_n  = 1'b1;
				bc_n     = '0;
			end
		end else if (b_end) begin
			// flush all held bytes plus this one
			n_emit   = cnt_q + 3'd1;
			has_last = 1'b1;
			last_idx = cnt_q;
			last_len = end_len;
			cnt_n    = 3'd0;
			inside_n = 1'b0;
			first_n  = 1'b0;
			bc_n     = '0;
		end else if (sc_inside) begin
			// next start code: close the unit, empty units vanish
			if (cnt_q == 3'd4) begin
				n_emit   = 3'd1;
				has_last = 1'b1;
				last_len = one_len;
			end
			cnt_n   = 3'd0;
			first_n = 1'b1;
			bc_n    = '0;
		end else if (cnt_q == 3'd4) begin
			// window full: oldest byte leaves
			n_emit   = 3'd1;
			win_n[0] = win_q[1];
			win_n[1] = win_q[2];
			win_n[2] = win_q[3];
			win_n[3] = b;
			first_n  = 1'b0;
			bc_n     = one_len;
		end else begin
			win_n[cnt_q[1:0]] = b;
			cnt_n = cnt_q + 3'd1;
		end
	end

	assign type_n = (n_emit != 3'd0) ? hdr_type : type_q;

	// Result fields for each emitted byte
	always_comb begin
		for (int k = 0; k < nalsplit_pkg::MAX_EMIT; k++) begin
			res[k].out_byte       = q_byte[k];
			res[k].first_of_nal   = first_q && (k == 0);
			res[k].last_of_nal    = has_last && (3'(k) == last_idx);
			res[k].nal_type       = hdr_type;
			res[k].key_frame      = hdr_type == nalsplit_pkg::NAL_TYPE_IDR;
			res[k].payload_length = (has_last && (3'(k) == last_idx))
				? nalsplit_pkg::PLEN_W'(last_len) : '0;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < nalsplit_pkg::WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			cnt_q    <= 3'd0;
			inside_q <= 1'b0;
			first_q  <= 1'b0;
			type_q   <= '0;
			bc_q     <= '0;
		end else if (push) begin
			win_q    <= win_n;
			cnt_q    <= cnt_n;
			inside_q <= inside_n;
			first_q  <= first_n;
			type_q   <= type_n;
			bc_q     <= bc_n;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < nalsplit_pkg::MAX_EMIT; k++) begin
			if (push && 3'(k) < n_emit) begin
				queue_q[wr_ptr_q + nalsplit_pkg::QPTR_W'(k)] <= res[k];
			end
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			qcnt_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + nalsplit_pkg::QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			qcnt_q <= qcnt_q + push_cnt - nalsplit_pkg::QCNT_W'(pop);
		end
	end

	// Output transaction payload
	assign nal_stream.out_byte       = queue_q[rd_ptr_q].out_byte;
	assign nal_stream.first_of_nal   = queue_q[rd_ptr_q].first_of_nal;
	assign nal_stream.last_of_nal    = queue_q[rd_ptr_q].last_of_nal;
	assign nal_stream.nal_type       = queue_q[rd_ptr_q].nal_type;
	assign nal_stream.key_frame      = queue_q[rd_ptr_q].key_frame;
	assign nal_stream.payload_length = queue_q[rd_ptr_q].payload_length;

endmodule

FILE: test/tb_annexb_nal_unit_splitter.sv
// Self-checking testbench for the Annex B NAL unit splitter.
// Depends on nalsplit_pkg, nalsplit_in_if, nalsplit_out_if and the RTL top level;
// a scoreboard class predicts every payload transaction from the accepted bytes.
`timescale 1ns / 1ps

module tb_annexb_nal_unit_splitter;

	localparam logic [nalsplit_pkg::TYPE_W-1:0] NAL_SPS = 5'd7;
	localparam logic [nalsplit_pkg::TYPE_W-1:0] NAL_PPS = 5'd8;
	localparam int RAND_UNIT_BYTES = 130;
	localparam int CALM_AFTER      = 100;

	// Tracks the splitter's state and the payload bytes still owed
	class nal_payload_checker;
		nalsplit_pkg::byte_t                  window[4];
		int unsigned                          held;
		bit                                   in_unit;
		bit                                   header_next;
		logic [nalsplit_pkg::TYPE_W-1:0]      unit_type;
		logic [nalsplit_pkg::LENGTH_BITS-1:0] unit_len;
		nalsplit_pkg::nal_res_t               owed_bytes[$];
		int unsigned                          mismatches;

		function new();
			mismatches = 0;
			unit_type  = '0;
			back_to_search();
		endfunction

		function void clear_window();
			for (int i = 0; i < 4; i++) begin
				window[i] = '0;
			end
			held = 0;
		endfunction

		function void back_to_search();
			clear_window();
			in_unit     = 1'b0;
			header_next = 1'b0;
			unit_len    = '0;
		endfunction

		// One payload byte leaves; the header byte latches the unit type
		function void owe_payload(nalsplit_pkg::byte_t b, bit last);
			nalsplit_pkg::nal_res_t r;
			r.first_of_nal = header_next;
			if (header_next) begin
				unit_type   = nalsplit_pkg::TYPE_W'(b & nalsplit_pkg::NAL_TYPE_MASK);
				header_next = 1'b0;
			end
			if (unit_len != nalsplit_pkg::LEN_MAX) begin
				unit_len++;
			end
			r.out_byte       = b;
			r.last_of_nal    = last;
			r.nal_type       = unit_type;
			r.key_frame      = (unit_type == nalsplit_pkg::NAL_TYPE_IDR);
			r.payload_length = last ? nalsplit_pkg::PLEN_W'(unit_len) : '0;
			owed_bytes.push_back(r);
			if (last) begin
				unit_len = '0;
			end
		endfunction

		// Accepted input byte: advance the state, queue what it releases
		function void take_stream_byte(nalsplit_pkg::byte_t b, bit eob);
			nalsplit_pkg::byte_t q[5];
			int unsigned         cnt;
			cnt = held;
			if (!in_unit) begin
				window[0] = window[1];
				window[1] = window[2];
				window[2] = window[3];
				window[3] = b;
				if (held < 4) begin
					held++;
				end
				if (eob) begin
					back_to_search();
				end else if (held == 4 && window[0] == nalsplit_pkg::SC_ZERO &&
						window[1] == nalsplit_pkg::SC_ZERO &&
						window[2] == nalsplit_pkg::SC_ZERO &&
						window[3] == nalsplit_pkg::SC_ONE) begin
					clear_window();
					in_unit     = 1'b1;
					header_next = 1'b1;
					unit_len    = '0;
				end
				return;
			end
			for (int i = 0; i < cnt; i++) begin
				q[i] = window[i];
			end
			q[cnt] = b;
			// buffer end: everything held goes out, this byte is data
			if (eob) begin
				for (int i = 0; i <= cnt; i++) begin
					owe_payload(q[i], i == cnt);
				end
				back_to_search();
				return;
			end
			// start code inside a unit closes it; empty units vanish
			if (cnt >= 3 && q[cnt-3] == nalsplit_pkg::SC_ZERO &&
					q[cnt-2] == nalsplit_pkg::SC_ZERO &&
					q[cnt-1] == nalsplit_pkg::SC_ZERO && b == nalsplit_pkg::SC_ONE) begin
				if (cnt == 4) begin
					owe_payload(q[0], 1'b1);
				end
				clear_window();
				header_next = 1'b1;
				unit_len    = '0;
				return;
			end
			if (cnt == 4) begin
				owe_payload(q[0], 1'b0);
				for (int i = 0; i < 4; i++) begin
					window[i] = q[i+1];
				end
				held = 4;
			end else begin
				window[cnt] = b;
				held        = cnt + 1;
			end
		endfunction

		// Output transaction against the oldest owed byte
		function void compare_payload_byte(nalsplit_pkg::nal_res_t got);
			nalsplit_pkg::nal_res_t want;
			if (owed_bytes.size() == 0) begin
				$error("unexpected payload transaction, out_byte %h", got.out_byte);
				mismatches++;
				return;
			end
			want = owed_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				mismatches++;
			end
			if (got.first_of_nal !== want.first_of_nal) begin
				$error("first_of_nal: expected %b, got %b", want.first_of_nal, got.first_of_nal);
				mismatches++;
			end
			if (got.last_of_nal !== want.last_of_nal) begin
				$error("last_of_nal: expected %b, got %b", want.last_of_nal, got.last_of_nal);
				mismatches++;
			end
			if (got.nal_type !== want.nal_type) begin
				$error("nal_type: expected %0d, got %0d", want.nal_type, got.nal_type);
				mismatches++;
			end
			if (got.key_frame !== want.key_frame) begin
				$error("key_frame: expected %b, got %b", want.key_frame, got.key_frame);
				mismatches++;
			end
			if (got.payload_length !== want.payload_length) begin
				$error("payload_length: expected %0d, got %0d",
					want.payload_length, got.payload_length);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   feed_idle  = 1'b1;
	bit   drain_stall = 1'b1;

	nal_payload_checker     sb = new();
	nalsplit_pkg::nal_res_t seen;

	nalsplit_in_if  byte_if ();
	nalsplit_out_if nal_if ();

	annexb_nal_unit_splitter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_if),
		.nal_stream (nal_if)
	);

	always #10 clk = ~clk;

	// Hard limit on run time
	initial begin
		#100_000_000;
		$display("FAILURE");
		$finish;
	end

	// Watch both channels; values are the ones present before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_if.valid && byte_if.ready) begin
				sb.take_stream_byte(byte_if.data_byte, byte_if.buffer_end);
			end
			if (nal_if.valid && nal_if.ready) begin
				seen.out_byte       = nal_if.out_byte;
				seen.first_of_nal   = nal_if.first_of_nal;
				seen.last_of_nal    = nal_if.last_of_nal;
				seen.nal_type       = nal_if.nal_type;
				seen.key_frame      = nal_if.key_frame;
				seen.payload_length = nal_if.payload_length;
				sb.compare_payload_byte(seen);
			end
		end
	end

	// Output side: random stall bursts, steady when drain_stall is off
	initial begin
		nal_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (drain_stall && $urandom_range(0, 3) == 0) begin
				nal_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			nal_if.ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	end

	// One byte transaction; returns at the edge where it is taken
	task automatic send_byte(input nalsplit_pkg::byte_t d, input bit eob);
		if (feed_idle && $urandom_range(0, 3) == 0) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		byte_if.valid      <= 1'b1;
		byte_if.data_byte  <= d;
		byte_if.buffer_end <= eob;
		do @(posedge clk); while (!byte_if.ready);
	endtask

	task automatic send_start_code(input bit eob);
		send_byte(nalsplit_pkg::SC_ZERO, 1'b0);
		send_byte(nalsplit_pkg::SC_ZERO, 1'b0);
		send_byte(nalsplit_pkg::SC_ZERO, 1'b0);
		send_byte(nalsplit_pkg::SC_ONE, eob);
	endtask

	function automatic nalsplit_pkg::byte_t pick_header();
		logic [nalsplit_pkg::TYPE_W-1:0] t;
		case ($urandom_range(0, 3))
			0: t = nalsplit_pkg::NAL_TYPE_IDR;
			1: t = NAL_SPS;
			2: t = NAL_PPS;
			default: t = nalsplit_pkg::TYPE_W'($urandom_range(0, 31));
		endcase
		return {3'($urandom_range(0, 7)), t};
	endfunction

	function automatic nalsplit_pkg::byte_t pick_payload();
		return ($urandom_range(0, 3) == 0) ? nalsplit_pkg::SC_ZERO
			: nalsplit_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	initial begin
		int                  unit_bytes;
		int                  plen;
		bit                  close_eob;
		nalsplit_pkg::byte_t b;

		arst_n             <= 1'b0;
		byte_if.valid      <= 1'b0;
		byte_if.data_byte  <= '0;
		byte_if.buffer_end <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: start code on a buffer end while searching opens nothing
		send_start_code(1'b1);
		// SPS of one byte closed by the next start code
		send_start_code(1'b0);
		send_byte(8'h67, 1'b0);
		send_start_code(1'b0);
		// back-to-back start codes: empty unit dropped
		send_start_code(1'b0);
		// IDR unit flushed on buffer end; trailing start code counts as data
		send_byte(8'hE5, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_start_code(1'b1);
		// single-byte unit ending the buffer
		send_start_code(1'b0);
		send_byte(8'h68, 1'b1);

		// Random: mostly well-formed units, some noise and broken start codes
		unit_bytes = 0;
		while (unit_bytes < RAND_UNIT_BYTES) begin
			if (unit_bytes >= CALM_AFTER) begin
				feed_idle   = 1'b0;
				drain_stall = 1'b0;
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: b = nalsplit_pkg::SC_ZERO;
						1: b = nalsplit_pkg::SC_ONE;
						default: b = nalsplit_pkg::byte_t'($urandom_range(0, 255));
					endcase
					send_byte(b, $urandom_range(0, 7) == 0);
				end
			end else begin
				plen      = $urandom_range(0, 8);
				close_eob = ($urandom_range(0, 3) == 0);
				send_start_code(1'b0);
				send_byte(pick_header(), close_eob && plen == 0);
				for (int i = 0; i < plen; i++) begin
					send_byte(pick_payload(), close_eob && i == plen - 1);
				end
				unit_bytes += 5 + plen;
			end
		end

		// Short IDR unit that ends the last buffer and flushes what is held
		feed_idle   = 1'b0;
		drain_stall = 1'b0;
		send_start_code(1'b0);
		send_byte(8'h65, 1'b0);
		send_byte(8'hA5, 1'b1);
		byte_if.valid <= 1'b0;

		// Drain, then give the block time to show any stray output
		while (sb.owed_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.mismatches == 0 && sb.owed_bytes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
